FILE: sv/mkdat_pkg.sv
// shared types and constants of the key debounce action tracker
`timescale 1ns / 1ps
package mkdat_pkg;

   localparam int NUM_KEYS_DEF = 8;

   localparam int OP_W     = 2;
   localparam int KEY_W    = 3;
   localparam int TIME_W   = 16;
   localparam int CLICK_W  = 8;
   localparam int COUNT_W  = 2;
   localparam int MASK_W   = 8;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [TIME_W-1:0]  TIMER_MAX = 16'hFFFF;
   localparam logic [CLICK_W-1:0] CLICK_MAX = 8'hFF;
   localparam logic [TIME_W-1:0]  CYCLE_MS_RESET    = 16'd10;
   localparam logic [TIME_W-1:0]  DEBOUNCE_MS_RESET = 16'd20;
   localparam logic [MASK_W-1:0]  NOTIFY_MASK_RESET = 8'd0;

   typedef enum logic [1:0] {
      ACT_IDLE     = 2'd0,
      ACT_PRESSED  = 2'd1,
      ACT_RELEASED = 2'd2
   } action_type;

   typedef enum logic [OP_W-1:0] {
      OP_TICK       = 2'd0,
      OP_SET_DELAY  = 2'd1,
      OP_GET_CLICKS = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      CSR_CYCLE_MS    = 2'd0,
      CSR_DEBOUNCE_MS = 2'd1,
      CSR_NOTIFY_MASK = 2'd2
   } csr_index_type;

   // one table entry per key
   typedef struct packed {
      action_type          action;
      action_type          prev_action;
      logic [TIME_W-1:0]   press_timer;
      logic [TIME_W-1:0]   release_timer;
      logic [TIME_W-1:0]   countdown;
      logic [CLICK_W-1:0]  clicks;
   } key_entry_type;

   typedef struct packed {
      logic [TIME_W-1:0] cycle_ms;
      logic [TIME_W-1:0] debounce_ms;
      logic              notify_en;
   } step_cfg_type;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic              closed;
      logic [TIME_W-1:0] time_value;
   } step_req_type;

endpackage

FILE: sv/mkdat_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps
interface mkdat_req_if import mkdat_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [KEY_W-1:0]  key;
   logic              pressed;
   logic [TIME_W-1:0] time_value;

   modport source (output valid, op, key, pressed, time_value, input ready);
   modport sink   (input valid, op, key, pressed, time_value, output ready);
endinterface

interface mkdat_rsp_if import mkdat_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] notify_count;
   logic [1:0]         action_now;
   logic [TIME_W-1:0]  press_time;
   logic [TIME_W-1:0]  release_time;
   logic [CLICK_W-1:0] click_result;

   modport source (output valid, notify_count, action_now, press_time, release_time,
                   click_result, input ready);
   modport sink   (input valid, notify_count, action_now, press_time, release_time,
                   click_result, output ready);
endinterface

FILE: sv/multi_key_debounce_action_tracker_core.sv
// top level of the key debounce action tracker with its table memory
`timescale 1ns / 1ps
//
//  channel   direction  handshake              carries
//  req_chan  in         valid/ready            op, key, pressed, time_value
//  rsp_chan  out        valid/ready            notify_count, action_now, times, clicks
//  apb       in         psel/penable/pready    cycle_ms, debounce_ms, notify_enable_mask
//
//  per request the key's entry is first read from the table memory into a register,
//  then updated, written back and loaded into the response register
//  only one request is in flight, so a read never sees a stale entry
//  a response that is not taken holds the update cycle; a new request is still
//  accepted while the last response waits
//  reset clears a per-key valid bit; an entry that is not valid reads as all zero,
//  so no clearing pass is needed
module multi_key_debounce_action_tracker_core import mkdat_pkg::*; #(
   parameter int NUM_KEYS = NUM_KEYS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   mkdat_req_if.sink             req_chan,
   mkdat_rsp_if.source           rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

   // configuration registers
   logic [TIME_W-1:0] cycle_ms_ff;
   logic [TIME_W-1:0] debounce_ms_ff;
   logic [MASK_W-1:0] notify_mask_ff;
   logic              csr_write;
   csr_index_type     csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = csr_index_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cycle_ms_ff    <= CYCLE_MS_RESET;
         debounce_ms_ff <= DEBOUNCE_MS_RESET;
         notify_mask_ff <= NOTIFY_MASK_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_CYCLE_MS:    cycle_ms_ff    <= pwdata[TIME_W-1:0];
            CSR_DEBOUNCE_MS: debounce_ms_ff <= pwdata[TIME_W-1:0];
            CSR_NOTIFY_MASK: notify_mask_ff <= pwdata[MASK_W-1:0];
            default: begin
               // writes outside the register list are dropped
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_CYCLE_MS:    prdata = CSR_DATA_W'(cycle_ms_ff);
         CSR_DEBOUNCE_MS: prdata = CSR_DATA_W'(debounce_ms_ff);
         CSR_NOTIFY_MASK: prdata = CSR_DATA_W'(notify_mask_ff);
         default:         prdata = '0;
      endcase
   end

   // request capture
   logic              busy_ff;
   logic              req_accept;
   logic              key_in_range;
   logic [IDX_W-1:0]  rd_addr;
   step_req_type      step_req_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [IDX_W-1:0]  addr_ff;
   logic              in_range_ff;
   logic              hit_ff;

   assign req_chan.ready = !busy_ff;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign key_in_range   = 32'(req_chan.key) < NUM_KEYS;
   assign rd_addr        = IDX_W'(req_chan.key);

   // per-key table and its valid bits
   key_entry_type      table_mem [NUM_KEYS];
   key_entry_type      rd_data_ff;
   logic [NUM_KEYS-1:0] valid_ff;
   logic               wr_en;
   key_entry_type      cur_entry;
   key_entry_type      nxt_entry;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[addr_ff] <= nxt_entry;
      end
      if (req_accept) begin
         rd_data_ff <= table_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[addr_ff] <= 1'b1;
      end
   end

   // payload of the request in flight
   always_ff @(posedge clock) begin
      if (req_accept) begin
         step_req_ff.op         <= req_chan.op;
         step_req_ff.closed     <= req_chan.pressed;
         step_req_ff.time_value <= req_chan.time_value;
         key_ff                 <= req_chan.key;
         addr_ff                <= rd_addr;
         in_range_ff            <= key_in_range;
         hit_ff                 <= key_in_range && valid_ff[rd_addr];
      end
   end

   // an entry never written since reset reads as its reset value
   assign cur_entry = hit_ff ? rd_data_ff : '0;

   // update
   step_cfg_type       step_cfg;
   logic [COUNT_W-1:0] step_count;
   logic [CLICK_W-1:0] step_clicks;
   logic               done;

   assign step_cfg.cycle_ms    = cycle_ms_ff;
   assign step_cfg.debounce_ms = debounce_ms_ff;
   assign step_cfg.notify_en   = notify_mask_ff[key_ff];

   mkdat_step u_step (
      .cur          (cur_entry),
      .req          (step_req_ff),
      .cfg          (step_cfg),
      .nxt          (nxt_entry),
      .notify_count (step_count),
      .click_result (step_clicks)
   );

   logic rsp_valid_ff;

   // update only when the response register is free
   assign done  = busy_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign wr_en = done && in_range_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            busy_ff <= 1'b1;
         end else if (done) begin
            busy_ff <= 1'b0;
         end
         if (done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response register; a key outside the bank answers all zero
   logic [COUNT_W-1:0] rsp_count_ff;
   logic [1:0]         rsp_action_ff;
   logic [TIME_W-1:0]  rsp_press_ff;
   logic [TIME_W-1:0]  rsp_release_ff;
   logic [CLICK_W-1:0] rsp_clicks_ff;

   always_ff @(posedge clock) begin
      if (done) begin
         if (in_range_ff) begin
            rsp_count_ff   <= step_count;
            rsp_action_ff  <= nxt_entry.action;
            rsp_press_ff   <= nxt_entry.press_timer;
            rsp_release_ff <= nxt_entry.release_timer;
            rsp_clicks_ff  <= step_clicks;
         end else begin
            rsp_count_ff   <= '0;
            rsp_action_ff  <= '0;
            rsp_press_ff   <= '0;
            rsp_release_ff <= '0;
            rsp_clicks_ff  <= '0;
         end
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.notify_count = rsp_count_ff;
   assign rsp_chan.action_now   = rsp_action_ff;
   assign rsp_chan.press_time   = rsp_press_ff;
   assign rsp_chan.release_time = rsp_release_ff;
   assign rsp_chan.click_result = rsp_clicks_ff;

endmodule

FILE: sv/mkdat_step.sv
// next-state logic for one key entry
`timescale 1ns / 1ps
module mkdat_step import mkdat_pkg::*; (
   input  key_entry_type      cur,
   input  step_req_type       req,
   input  step_cfg_type       cfg,
   output key_entry_type      nxt,
   output logic [COUNT_W-1:0] notify_count,
   output logic [CLICK_W-1:0] click_result
);

   function automatic logic [TIME_W-1:0] grow(input logic [TIME_W-1:0] t,
                                              input logic [TIME_W-1:0] cyc);
      logic [TIME_W:0] limit;
      logic [TIME_W:0] sum;
      limit = {1'b0, TIMER_MAX} - {1'b0, cyc};
      sum   = {1'b0, t} + {1'b0, cyc};
      if ({1'b0, t} < limit) begin
         return sum[TIME_W-1:0];
      end
      return t;
   endfunction

   action_type         tick_action;
   logic [TIME_W-1:0]  tick_press;
   logic [TIME_W-1:0]  tick_release;
   logic [TIME_W-1:0]  tick_countdown;
   logic [COUNT_W-1:0] tick_count;

   // debounce of the raw level
   always_comb begin
      tick_action  = cur.action;
      tick_press   = cur.press_timer;
      tick_release = cur.release_timer;
      if (!req.closed) begin
         if (cur.action == ACT_PRESSED) begin
            tick_release = grow(cur.release_timer, cfg.cycle_ms);
            if (tick_release >= cfg.debounce_ms) begin
               tick_action = ACT_RELEASED;
            end
         end else begin
            tick_action  = ACT_IDLE;
            tick_press   = '0;
            tick_release = grow(cur.release_timer, cfg.cycle_ms);
         end
      end else if (cur.action != ACT_RELEASED) begin
         if (cur.action == ACT_PRESSED) begin
            tick_release = '0;
         end
         tick_press = grow(cur.press_timer, cfg.cycle_ms);
         if (tick_press >= cfg.debounce_ms) begin
            tick_action = ACT_PRESSED;
         end
      end else begin
         // closed again while released: bounce
         tick_action  = ACT_IDLE;
         tick_press   = '0;
         tick_release = TIME_W'(1);
      end
   end

   // delayed notify and change notify
   always_comb begin
      tick_countdown = cur.countdown;
      tick_count     = '0;
      if (cfg.notify_en) begin
         if (cur.countdown != '0) begin
            if (cur.countdown >= cfg.cycle_ms) begin
               tick_countdown = cur.countdown - cfg.cycle_ms;
            end else begin
               tick_countdown = '0;
            end
            if (tick_countdown == '0) begin
               tick_count = COUNT_W'(1);
            end
         end
         if (tick_action != cur.prev_action) begin
            tick_count = tick_count + COUNT_W'(1);
         end
      end
   end

   always_comb begin
      nxt          = cur;
      notify_count = '0;
      click_result = '0;
      case (op_type'(req.op))
         OP_TICK: begin
            nxt.action        = tick_action;
            nxt.prev_action   = tick_action;
            nxt.press_timer   = tick_press;
            nxt.release_timer = tick_release;
            nxt.countdown     = tick_countdown;
            notify_count      = tick_count;
         end
         OP_SET_DELAY: begin
            nxt.countdown = req.time_value;
         end
         OP_GET_CLICKS: begin
            case (cur.action)
               ACT_RELEASED: begin
                  nxt.countdown = req.time_value;
               end
               ACT_PRESSED: begin
                  if (cur.clicks < CLICK_MAX) begin
                     nxt.clicks = cur.clicks + CLICK_W'(1);
                  end
               end
               ACT_IDLE: begin
                  if (cur.release_timer >= req.time_value) begin
                     click_result = cur.clicks;
                     nxt.clicks   = '0;
                  end
               end
               default: begin
                  nxt = cur;
               end
            endcase
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

FILE: test/multi_key_debounce_action_tracker_core_tb.sv
// self-checking testbench for the key debounce action tracker core
`timescale 1ns / 1ps
module multi_key_debounce_action_tracker_core_tb;
   import mkdat_pkg::*;

   localparam int HALF_PERIOD  = 10;
   localparam int STALL_MAX    = 6;
   localparam int ITEM_GOAL    = 850;
   localparam int PHASE_ITEMS  = 120;
   localparam int IDLE_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int REPORT_MAX   = 10;
   // op code the block does not define: state is reported, nothing changes
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   // one response as the block should present it
   typedef struct packed {
      logic [COUNT_W-1:0] notify_count;
      logic [1:0]         action_now;
      logic [TIME_W-1:0]  press_time;
      logic [TIME_W-1:0]  release_time;
      logic [CLICK_W-1:0] click_result;
   } key_result_type;

   // own copy of the key table and registers, plus the responses still owed
   class key_tracker_board;
      logic [TIME_W-1:0]  cycle_ms;
      logic [TIME_W-1:0]  debounce_ms;
      logic [MASK_W-1:0]  notify_mask;
      action_type         action[NUM_KEYS_DEF];
      action_type         last_action[NUM_KEYS_DEF];
      logic [TIME_W-1:0]  press_t[NUM_KEYS_DEF];
      logic [TIME_W-1:0]  release_t[NUM_KEYS_DEF];
      logic [TIME_W-1:0]  countdown[NUM_KEYS_DEF];
      logic [CLICK_W-1:0] clicks[NUM_KEYS_DEF];
      key_result_type     owed_results[$];
      int                 mismatches;

      function new();
         cycle_ms    = CYCLE_MS_RESET;
         debounce_ms = DEBOUNCE_MS_RESET;
         notify_mask = NOTIFY_MASK_RESET;
         mismatches  = 0;
         for (int k = 0; k < NUM_KEYS_DEF; k++) begin
            action[k]      = ACT_IDLE;
            last_action[k] = ACT_IDLE;
            press_t[k]     = '0;
            release_t[k]   = '0;
            countdown[k]   = '0;
            clicks[k]      = '0;
         end
      endfunction

      function void set_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_CYCLE_MS:    cycle_ms    = value[TIME_W-1:0];
            CSR_DEBOUNCE_MS: debounce_ms = value[TIME_W-1:0];
            CSR_NOTIFY_MASK: notify_mask = value[MASK_W-1:0];
            default: ;
         endcase
      endfunction

      // timers only grow while there is room below the ceiling
      function logic [TIME_W-1:0] grow(logic [TIME_W-1:0] t);
         if (int'(t) < int'(TIMER_MAX) - int'(cycle_ms))
            return t + cycle_ms;
         return t;
      endfunction

      function logic [COUNT_W-1:0] advance_tick(int k, logic closed);
         int notes = 0;
         if (!closed) begin
            if (action[k] == ACT_PRESSED) begin
               release_t[k] = grow(release_t[k]);
               if (release_t[k] >= debounce_ms)
                  action[k] = ACT_RELEASED;
            end else begin
               action[k]    = ACT_IDLE;
               press_t[k]   = '0;
               release_t[k] = grow(release_t[k]);
            end
         end else if (action[k] != ACT_RELEASED) begin
            if (action[k] == ACT_PRESSED)
               release_t[k] = '0;
            press_t[k] = grow(press_t[k]);
            if (press_t[k] >= debounce_ms)
               action[k] = ACT_PRESSED;
         end else begin
            // bounce: closed again right after release
            action[k]    = ACT_IDLE;
            press_t[k]   = '0;
            release_t[k] = 16'd1;
         end
         if (notify_mask[k]) begin
            if (countdown[k] != 0) begin
               countdown[k] = (countdown[k] >= cycle_ms) ? countdown[k] - cycle_ms : '0;
               if (countdown[k] == 0)
                  notes++;
            end
            if (action[k] != last_action[k])
               notes++;
         end
         last_action[k] = action[k];
         return notes[COUNT_W-1:0];
      endfunction

      function logic [CLICK_W-1:0] fetch_clicks(int k, logic [TIME_W-1:0] gap);
         logic [CLICK_W-1:0] taken = '0;
         if (action[k] == ACT_RELEASED)
            countdown[k] = gap;
         if (action[k] == ACT_PRESSED && clicks[k] < CLICK_MAX)
            clicks[k]++;
         if (action[k] == ACT_IDLE && release_t[k] >= gap) begin
            taken     = clicks[k];
            clicks[k] = '0;
         end
         return taken;
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key, logic closed,
                                 logic [TIME_W-1:0] tv);
         key_result_type r;
         int k;
         k = key;
         r = '0;
         case (op)
            OP_TICK:       r.notify_count = advance_tick(k, closed);
            OP_SET_DELAY:  countdown[k] = tv;
            OP_GET_CLICKS: r.click_result = fetch_clicks(k, tv);
            default: ;
         endcase
         r.action_now   = action[k];
         r.press_time   = press_t[k];
         r.release_time = release_t[k];
         owed_results.push_back(r);
      endfunction

      function void flag(string what, key_result_type exp, key_result_type got);
         mismatches++;
         if (mismatches <= REPORT_MAX)
            $display("%0t %s: expected n=%0d a=%0d p=%0d r=%0d c=%0d, got n=%0d a=%0d p=%0d r=%0d c=%0d",
                     $realtime, what, exp.notify_count, exp.action_now, exp.press_time,
                     exp.release_time, exp.click_result, got.notify_count, got.action_now,
                     got.press_time, got.release_time, got.click_result);
      endfunction

      function void check_response(key_result_type got);
         key_result_type exp;
         if (owed_results.size() == 0) begin
            flag("response with nothing owed", '0, got);
            return;
         end
         exp = owed_results.pop_front();
         if (got.notify_count !== exp.notify_count || got.action_now !== exp.action_now ||
             got.press_time !== exp.press_time || got.release_time !== exp.release_time ||
             got.click_result !== exp.click_result)
            flag("response differs", exp, got);
      endfunction

      function void close_out();
         if (owed_results.size() != 0) begin
            if (mismatches < REPORT_MAX)
               $display("%0d responses never arrived", owed_results.size());
            mismatches += owed_results.size();
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   mkdat_req_if req_chan ();
   mkdat_rsp_if rsp_chan ();

   key_tracker_board board = new();

   // random idling controls; a calm stretch runs back to back
   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;
   int rsp_hold = 0;
   int quiet_cycles = 0;
   int requests_sent = 0;

   multi_key_debounce_action_tracker_core #(
      .NUM_KEYS(NUM_KEYS_DEF)
   ) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // response side: check every accepted response, then stall a random while
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         board.check_response({rsp_chan.notify_count, rsp_chan.action_now,
                               rsp_chan.press_time, rsp_chan.release_time,
                               rsp_chan.click_result});
         rsp_hold = rsp_calm ? 0 : $urandom_range(0, STALL_MAX);
      end else if (rsp_hold > 0) begin
         rsp_hold--;
      end
      rsp_chan.ready <= (rsp_hold == 0);
   end

   // watchdog: too long without any handshake means the block hung
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // register write over the apb port: setup, access until pready, then back to idle
   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(idx) << 2;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      board.set_reg(idx, value);
   endtask

   // one request: optional gap with valid low, then hold until accepted
   task automatic send_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key, logic closed,
                               logic [TIME_W-1:0] tv);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, STALL_MAX);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.op         <= op;
      req_chan.key        <= key;
      req_chan.pressed    <= closed;
      req_chan.time_value <= tv;
      do @(posedge clock); while (!req_chan.ready);
      board.note_request(op, key, closed, tv);
      requests_sent++;
   endtask

   // drop valid and let every owed response come back before touching registers
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (board.owed_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(logic [TIME_W-1:0] cyc, logic [TIME_W-1:0] deb,
                             logic [MASK_W-1:0] mask);
      write_reg(CSR_CYCLE_MS, CSR_DATA_W'(cyc));
      write_reg(CSR_DEBOUNCE_MS, CSR_DATA_W'(deb));
      write_reg(CSR_NOTIFY_MASK, CSR_DATA_W'(mask));
   endtask

   // mostly small gaps, sometimes the extremes or anything at all
   function automatic logic [TIME_W-1:0] pick_time();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return TIMER_MAX;
         2, 3:    return TIME_W'($urandom);
         default: return TIME_W'($urandom_range(0, 120));
      endcase
   endfunction

   // a full click on one key: press, maybe count clicks, release, fetch
   task automatic run_click(logic [KEY_W-1:0] k);
      repeat ($urandom_range(1, 6)) begin
         send_request(OP_TICK, k, 1'b1, TIME_W'($urandom));
         if ($urandom_range(0, 2) == 0)
            send_request(OP_GET_CLICKS, k, 1'($urandom_range(0, 1)), pick_time());
      end
      if ($urandom_range(0, 2) == 0)
         send_request(OP_SET_DELAY, k, 1'($urandom_range(0, 1)), TIME_W'($urandom_range(0, 60)));
      repeat ($urandom_range(1, 6))
         send_request(OP_TICK, k, 1'b0, TIME_W'($urandom));
      // catches the released action before the next tick clears it
      send_request(OP_GET_CLICKS, k, 1'($urandom_range(0, 1)), pick_time());
      if ($urandom_range(0, 3) == 0)
         send_request(OP_TICK, k, 1'b1, TIME_W'($urandom));
      repeat ($urandom_range(0, 4))
         send_request(OP_TICK, k, 1'b0, TIME_W'($urandom));
      send_request(OP_GET_CLICKS, k, 1'($urandom_range(0, 1)), TIME_W'($urandom_range(0, 80)));
   endtask

   task automatic run_noise();
      repeat ($urandom_range(1, 8))
         send_request(OP_W'($urandom_range(0, 3)), KEY_W'($urandom_range(0, NUM_KEYS_DEF - 1)),
                      1'($urandom_range(0, 1)), pick_time());
   endtask

   task automatic run_phase(logic [TIME_W-1:0] cyc, logic [TIME_W-1:0] deb,
                            logic [MASK_W-1:0] mask);
      int goal;
      set_config(cyc, deb, mask);
      goal = requests_sent + PHASE_ITEMS;
      while (requests_sent < goal && requests_sent < ITEM_GOAL) begin
         req_calm = ($urandom_range(0, 5) == 0);
         rsp_calm = ($urandom_range(0, 5) == 0);
         if ($urandom_range(0, 4) != 0)
            run_click(KEY_W'($urandom_range(0, NUM_KEYS_DEF - 1)));
         else
            run_noise();
      end
      drain();
   endtask

   initial begin
      reset               = 1'b1;
      psel                = 1'b0;
      penable             = 1'b0;
      pwrite              = 1'b0;
      paddr               = '0;
      pwdata              = '0;
      req_chan.valid      = 1'b0;
      req_chan.op         = OP_TICK;
      req_chan.key        = '0;
      req_chan.pressed    = 1'b0;
      req_chan.time_value = '0;
      rsp_chan.ready      = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values: notifications masked, default debounce
      send_request(OP_TICK, 3'd0, 1'b1, '0);
      send_request(OP_TICK, 3'd0, 1'b1, TIMER_MAX);
      send_request(OP_GET_CLICKS, 3'd0, 1'b0, '0);
      drain();

      // directed walk through press, clicks, countdown, release and bounce
      set_config(CYCLE_MS_RESET, DEBOUNCE_MS_RESET, 8'hFF);
      send_request(OP_SET_DELAY, 3'd1, 1'b0, 16'd25);
      send_request(OP_TICK, 3'd1, 1'b1, '0);
      send_request(OP_TICK, 3'd1, 1'b1, '0);
      send_request(OP_GET_CLICKS, 3'd1, 1'b1, '0);
      send_request(OP_GET_CLICKS, 3'd1, 1'b0, TIMER_MAX);
      send_request(OP_TICK, 3'd1, 1'b0, '0);
      send_request(OP_TICK, 3'd1, 1'b0, '0);
      send_request(OP_GET_CLICKS, 3'd1, 1'b0, 16'd40);
      send_request(OP_TICK, 3'd1, 1'b1, '0);
      send_request(OP_GET_CLICKS, 3'd1, 1'b0, '0);
      send_request(OP_UNUSED, 3'd1, 1'b1, TIMER_MAX);
      send_request(OP_TICK, 3'd7, 1'b1, TIMER_MAX);
      send_request(OP_SET_DELAY, 3'd7, 1'b1, TIMER_MAX);
      send_request(OP_TICK, 3'd7, 1'b1, TIMER_MAX);
      send_request(OP_GET_CLICKS, 3'd7, 1'b1, TIMER_MAX);
      send_request(OP_TICK, 3'd7, 1'b0, '0);
      send_request(OP_TICK, 3'd7, 1'b0, '0);
      send_request(OP_TICK, 3'd7, 1'b0, '0);
      send_request(OP_GET_CLICKS, 3'd7, 1'b0, '0);
      send_request(OP_UNUSED, 3'd7, 1'b0, '0);
      drain();

      // random requests across several register settings, extremes included
      run_phase(CYCLE_MS_RESET, DEBOUNCE_MS_RESET, 8'hFF);
      run_phase(16'd1, 16'd0, 8'hFF);
      run_phase(TIMER_MAX, TIMER_MAX, 8'h00);
      run_phase(16'd30000, 16'd40000, 8'hFF);
      run_phase(16'd3, 16'd7, 8'hA5);
      while (requests_sent < ITEM_GOAL)
         run_phase(TIME_W'($urandom_range(1, 50)), TIME_W'($urandom_range(0, 100)),
                   MASK_W'($urandom));

      board.close_out();
      if (board.mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

FILE: files.f
sv/mkdat_pkg.sv
sv/mkdat_if.sv
sv/mkdat_step.sv
sv/multi_key_debounce_action_tracker_core.sv
test/multi_key_debounce_action_tracker_core_tb.sv
